// File: design/clep_pkg.sv
`default_nettype none

package clep_pkg;

   // Number of display rows the controller can address at most.
   localparam int unsigned MAX_ROWS = 4;

   localparam int unsigned CHAR_WIDTH     = 8;
   localparam int unsigned LINES_WIDTH    = 3;
   localparam int unsigned ROW_WIDTH      = 2;
   localparam int unsigned CTRL_WIDTH     = 3;
   localparam int unsigned ESC_NUM        = 5;
   localparam int unsigned COUNT_WIDTH    = 3;
   localparam int unsigned CSR_ADDR_WIDTH = 3;
   localparam int unsigned CSR_DATA_WIDTH = 32;

   // Register index of line_count on the configuration port.
   localparam logic REG_LINE_COUNT = 1'b0;

   localparam logic [LINES_WIDTH-1:0] LINE_COUNT_RESET   = 3'd4;
   localparam logic [CTRL_WIDTH-1:0]  DISPLAY_CTRL_RESET = 3'b100;

   // Characters of interest.
   localparam logic [CHAR_WIDTH-1:0] CH_ESC    = 8'h1b;
   localparam logic [CHAR_WIDTH-1:0] CH_LF     = 8'h0a;
   localparam logic [CHAR_WIDTH-1:0] CH_LBRACK = 8'h5b;
   localparam logic [CHAR_WIDTH-1:0] CH_QUERY  = 8'h3f;
   localparam logic [CHAR_WIDTH-1:0] CH_SEMI   = 8'h3b;
   localparam logic [CHAR_WIDTH-1:0] CH_ZERO   = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CH_TWO    = 8'h32;
   localparam logic [CHAR_WIDTH-1:0] CH_FIVE   = 8'h35;
   localparam logic [CHAR_WIDTH-1:0] CH_NINE   = 8'h39;
   localparam logic [CHAR_WIDTH-1:0] CH_UPPER_J = 8'h4a;
   localparam logic [CHAR_WIDTH-1:0] CH_UPPER_H = 8'h48;
   localparam logic [CHAR_WIDTH-1:0] CH_LOWER_H = 8'h68;
   localparam logic [CHAR_WIDTH-1:0] CH_LOWER_L = 8'h6c;

   // Controller command codes and register select values.
   localparam logic [CHAR_WIDTH-1:0] CMD_CLEAR    = 8'h01;
   localparam logic [CHAR_WIDTH-1:0] CMD_DISPLAY  = 8'h08;
   localparam logic [CHAR_WIDTH-1:0] CMD_SET_ADDR = 8'h80;
   localparam logic RS_COMMAND = 1'b0;
   localparam logic RS_DATA    = 1'b1;

   typedef struct packed {
      logic                  valid;
      logic [CHAR_WIDTH-1:0] bus_byte;
      logic                  reg_select;
   } result_type;

   // Start address of each display row.
   function automatic logic [CHAR_WIDTH-1:0] row_base(input logic [ROW_WIDTH-1:0] row);
      logic [CHAR_WIDTH-1:0] base;
      case (row)
         2'd0:    base = 8'h00;
         2'd1:    base = 8'h40;
         2'd2:    base = 8'h14;
         default: base = 8'h54;
      endcase
      return base;
   endfunction

   // Number of rows actually in use: zero counts as one, the top is capped.
   function automatic logic [LINES_WIDTH-1:0] lines_in_use(
      input logic [LINES_WIDTH-1:0] line_count);
      logic [LINES_WIDTH-1:0] lines;
      lines = line_count;
      if (lines == '0) begin
         lines = LINES_WIDTH'(1);
      end
      if (lines > LINES_WIDTH'(MAX_ROWS)) begin
         lines = LINES_WIDTH'(MAX_ROWS);
      end
      return lines;
   endfunction

   // Two-digit decimal value; the low nibble of an ASCII digit is its value.
   function automatic logic [CHAR_WIDTH-1:0] two_digits(
      input logic [CHAR_WIDTH-1:0] tens, input logic [CHAR_WIDTH-1:0] units);
      logic [CHAR_WIDTH-1:0] t;
      t = {4'b0000, tens[3:0]};
      return (t << 3) + (t << 1) + {4'b0000, units[3:0]};
   endfunction

endpackage

`default_nettype wire

// File: design/char_lcd_escape_parser_unit.sv
`default_nettype none

// Escape sequence parser for a character display controller. Each input
// transaction carries one text character; it yields at most one output
// transaction holding a byte for the controller and a register select
// (0 for the command register, 1 for the data register). Plain characters
// pass through as data, a newline becomes a set-address command for column 0
// of the next row, and ESC[2J, ESC[?25h, ESC[?25l and ESC[r;cH (one- or
// two-digit numbers) become clear, cursor on, cursor off and set-address
// commands; any other escape sequence produces nothing. The design takes one
// character per clock cycle: a character is captured in an input register,
// decoded by the parser against its small state registers once the output
// register can take the result, and the command or data byte lands in the
// output register. The output register is refilled in the same cycle in
// which it is emptied, so full throughput holds as long as the consumer keeps
// rsp_ready high. line_count (byte address 0 of the configuration port, reset
// value 4) sets the number of display rows and should only be written while
// the block is idle.

module char_lcd_escape_parser_unit (
   input  wire logic                                 clock,
   input  wire logic                                 reset,

   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic [clep_pkg::CHAR_WIDTH-1:0]      req_char_in,

   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic      [clep_pkg::CHAR_WIDTH-1:0]      rsp_bus_byte,
   output logic                                      rsp_reg_select,

   input  wire logic                                 csr_psel,
   input  wire logic                                 csr_penable,
   input  wire logic                                 csr_pwrite,
   input  wire logic [clep_pkg::CSR_ADDR_WIDTH-1:0]  csr_paddr,
   input  wire logic [clep_pkg::CSR_DATA_WIDTH-1:0]  csr_pwdata,
   output logic      [clep_pkg::CSR_DATA_WIDTH-1:0]  csr_prdata,
   output logic                                      csr_pready
);

   logic [clep_pkg::LINES_WIDTH-1:0] line_count;

   // Input register: holds one character waiting to be decoded.
   logic                            in_valid_ff, in_valid_in;
   logic [clep_pkg::CHAR_WIDTH-1:0] char_ff, char_in;

   // Output register: holds one finished transaction for the consumer.
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [clep_pkg::CHAR_WIDTH-1:0] bus_byte_ff, bus_byte_in;
   logic                            reg_select_ff, reg_select_in;

   logic                 req_accept;
   logic                 advance;
   clep_pkg::result_type result;

   clep_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (csr_psel),
      .penable    (csr_penable),
      .pwrite     (csr_pwrite),
      .paddr      (csr_paddr),
      .pwdata     (csr_pwdata),
      .prdata     (csr_prdata),
      .pready     (csr_pready),
      .line_count (line_count)
   );

   // The held character is decoded when the output register is free or is
   // being emptied in this very cycle. Every decode steps the parser state,
   // whether or not it produces an output transaction.
   assign advance    = in_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = !in_valid_ff || advance;
   assign req_accept = req_valid && req_ready;

   clep_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .char_in    (char_ff),
      .line_count (line_count),
      .result     (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      char_in     = char_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
         char_in     = req_char_in;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      bus_byte_in   = bus_byte_ff;
      reg_select_in = reg_select_ff;
      if (advance) begin
         rsp_valid_in  = result.valid;
         bus_byte_in   = result.bus_byte;
         reg_select_in = result.reg_select;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff       <= char_in;
      bus_byte_ff   <= bus_byte_in;
      reg_select_ff <= reg_select_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bus_byte   = bus_byte_ff;
   assign rsp_reg_select = reg_select_ff;

endmodule

`default_nettype wire

// File: design/clep_csr.sv
`default_nettype none

module clep_csr (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 psel,
   input  wire logic                                 penable,
   input  wire logic                                 pwrite,
   input  wire logic [clep_pkg::CSR_ADDR_WIDTH-1:0]  paddr,
   input  wire logic [clep_pkg::CSR_DATA_WIDTH-1:0]  pwdata,
   output logic      [clep_pkg::CSR_DATA_WIDTH-1:0]  prdata,
   output logic                                      pready,
   output logic      [clep_pkg::LINES_WIDTH-1:0]     line_count
);

   logic [clep_pkg::LINES_WIDTH-1:0] line_count_ff;
   logic [clep_pkg::LINES_WIDTH-1:0] line_count_in;
   logic                             reg_hit;

   // Registers sit on word addresses, so the word index is the top address bit.
   assign reg_hit = (paddr[clep_pkg::CSR_ADDR_WIDTH-1] == clep_pkg::REG_LINE_COUNT);

   always_comb begin
      line_count_in = line_count_ff;
      if (psel && penable && pwrite && pready && reg_hit) begin
         line_count_in = pwdata[clep_pkg::LINES_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_count_ff <= clep_pkg::LINE_COUNT_RESET;
      end else begin
         line_count_ff <= line_count_in;
      end
   end

   assign pready     = 1'b1;
   assign prdata     = reg_hit ? clep_pkg::CSR_DATA_WIDTH'(line_count_ff) : '0;
   assign line_count = line_count_ff;

endmodule

`default_nettype wire

// File: design/clep_parser.sv
`default_nettype none

module clep_parser (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                advance,
   input  wire logic [clep_pkg::CHAR_WIDTH-1:0]     char_in,
   input  wire logic [clep_pkg::LINES_WIDTH-1:0]    line_count,
   output clep_pkg::result_type                     result
);

   // Position within an escape sequence.
   localparam logic [clep_pkg::COUNT_WIDTH-1:0] POS_ESC     = 3'd0;
   localparam logic [clep_pkg::COUNT_WIDTH-1:0] POS_BRACKET = 3'd1;
   localparam logic [clep_pkg::COUNT_WIDTH-1:0] POS_FIRST   = 3'd2;
   localparam logic [clep_pkg::COUNT_WIDTH-1:0] POS_SECOND  = 3'd3;
   localparam logic [clep_pkg::COUNT_WIDTH-1:0] POS_THIRD   = 3'd4;
   localparam logic [clep_pkg::COUNT_WIDTH-1:0] POS_FOURTH  = 3'd5;
   localparam logic [clep_pkg::COUNT_WIDTH-1:0] POS_FIFTH   = 3'd6;

   logic [clep_pkg::COUNT_WIDTH-1:0] esc_count_ff, esc_count_in;
   logic [clep_pkg::CHAR_WIDTH-1:0]  digit_mask_ff, digit_mask_in;
   logic [clep_pkg::CHAR_WIDTH-1:0]  esc_chars_ff [clep_pkg::ESC_NUM];
   logic [clep_pkg::CHAR_WIDTH-1:0]  esc_chars_in [clep_pkg::ESC_NUM];
   logic [clep_pkg::ROW_WIDTH-1:0]   current_row_ff, current_row_in;
   logic [clep_pkg::CTRL_WIDTH-1:0]  display_ctrl_ff, display_ctrl_in;

   logic                             is_digit;
   logic                             keep;
   logic                             place_req;
   logic [clep_pkg::CHAR_WIDTH-1:0]  place_col;
   logic [clep_pkg::CHAR_WIDTH-1:0]  place_row;
   logic [clep_pkg::CHAR_WIDTH-1:0]  m;
   logic [clep_pkg::CHAR_WIDTH-1:0]  e2, e3, e4, e5, e6;
   logic [clep_pkg::LINES_WIDTH-1:0] lines;
   logic [clep_pkg::CHAR_WIDTH-1:0]  row_clamped;
   logic [clep_pkg::CTRL_WIDTH-1:0]  ctrl_next;

   assign is_digit = (char_in >= clep_pkg::CH_ZERO) && (char_in <= clep_pkg::CH_NINE);
   assign lines    = clep_pkg::lines_in_use(line_count);

   always_comb begin
      esc_count_in    = esc_count_ff;
      digit_mask_in   = digit_mask_ff;
      esc_chars_in    = esc_chars_ff;
      current_row_in  = current_row_ff;
      display_ctrl_in = display_ctrl_ff;
      result          = '0;
      keep            = 1'b0;
      place_req       = 1'b0;
      place_col       = '0;
      place_row       = '0;
      ctrl_next       = display_ctrl_ff;
      row_clamped     = '0;
      m               = '0;
      e2 = '0; e3 = '0; e4 = '0; e5 = '0; e6 = '0;

      if (char_in == clep_pkg::CH_LF) begin
         // A newline moves to column 0 of the next row, even inside an escape.
         place_req = 1'b1;
         place_row = clep_pkg::CHAR_WIDTH'(current_row_ff) + 8'd1;
      end else if (esc_count_ff != POS_ESC || char_in == clep_pkg::CH_ESC) begin
         if (esc_count_ff > POS_BRACKET) begin
            for (int i = 0; i < clep_pkg::ESC_NUM; i++) begin
               if (esc_count_ff == clep_pkg::COUNT_WIDTH'(i + 2)) begin
                  esc_chars_in[i] = char_in;
               end
            end
            if (is_digit) begin
               digit_mask_in = digit_mask_ff | 8'd1 | (8'd1 << esc_count_ff);
            end else begin
               digit_mask_in = digit_mask_ff & 8'hfe;
            end
         end
         m  = digit_mask_in;
         e2 = esc_chars_in[0];
         e3 = esc_chars_in[1];
         e4 = esc_chars_in[2];
         e5 = esc_chars_in[3];
         e6 = esc_chars_in[4];

         case (esc_count_ff)
            POS_ESC: begin
               keep = 1'b1;
            end
            POS_BRACKET: begin
               digit_mask_in = '0;
               keep = (char_in == clep_pkg::CH_LBRACK);
            end
            POS_FIRST: begin
               keep = (char_in == clep_pkg::CH_TWO) || (char_in == clep_pkg::CH_QUERY) || m[0];
            end
            POS_SECOND: begin
               if (e2 == clep_pkg::CH_QUERY) begin
                  keep = (char_in == clep_pkg::CH_TWO);
               end else if (e2 == clep_pkg::CH_TWO && char_in == clep_pkg::CH_UPPER_J) begin
                  current_row_in    = '0;
                  result.valid      = 1'b1;
                  result.bus_byte   = clep_pkg::CMD_CLEAR;
                  result.reg_select = clep_pkg::RS_COMMAND;
               end else begin
                  keep = m[2] && ((char_in == clep_pkg::CH_SEMI) || m[0]);
               end
            end
            POS_THIRD: begin
               if (e2 == clep_pkg::CH_QUERY) begin
                  keep = (e3 == clep_pkg::CH_TWO) && (char_in == clep_pkg::CH_FIVE);
               end else if (m[2]) begin
                  if (e3 == clep_pkg::CH_SEMI && m[0]) begin
                     keep = 1'b1;
                  end else if (m[3] && char_in == clep_pkg::CH_SEMI) begin
                     keep = 1'b1;
                  end
               end
            end
            POS_FOURTH: begin
               if (e2 == clep_pkg::CH_QUERY) begin
                  if (e3 == clep_pkg::CH_TWO && e4 == clep_pkg::CH_FIVE) begin
                     if (char_in == clep_pkg::CH_LOWER_H) begin
                        ctrl_next    = display_ctrl_ff | 3'b010;
                        result.valid = 1'b1;
                     end else if (char_in == clep_pkg::CH_LOWER_L) begin
                        ctrl_next    = display_ctrl_ff & 3'b101;
                        result.valid = 1'b1;
                     end
                     if (result.valid) begin
                        display_ctrl_in   = ctrl_next;
                        result.bus_byte   = clep_pkg::CMD_DISPLAY | {5'b00000, ctrl_next};
                        result.reg_select = clep_pkg::RS_COMMAND;
                     end
                  end
               end else if (m[2]) begin
                  if (e3 == clep_pkg::CH_SEMI && m[4]) begin
                     if (char_in == clep_pkg::CH_UPPER_H) begin
                        place_req = 1'b1;
                        place_col = {4'b0000, e4[3:0]};
                        place_row = {4'b0000, e2[3:0]};
                     end else if (m[0]) begin
                        keep = 1'b1;
                     end
                  end else if (m[3] && e4 == clep_pkg::CH_SEMI && m[0]) begin
                     keep = 1'b1;
                  end
               end
            end
            POS_FIFTH: begin
               if (m[2]) begin
                  if (e3 == clep_pkg::CH_SEMI && m[4] && m[5]
                      && char_in == clep_pkg::CH_UPPER_H) begin
                     place_req = 1'b1;
                     place_col = clep_pkg::two_digits(e4, e5);
                     place_row = {4'b0000, e2[3:0]};
                  end else if (m[3] && e4 == clep_pkg::CH_SEMI && m[5]) begin
                     if (char_in == clep_pkg::CH_UPPER_H) begin
                        place_req = 1'b1;
                        place_col = {4'b0000, e5[3:0]};
                        place_row = clep_pkg::two_digits(e2, e3);
                     end else if (m[0]) begin
                        keep = 1'b1;
                     end
                  end
               end
            end
            default: begin
               // The last possible character: it ends the sequence whatever it is.
               if (m[2] && m[3] && e4 == clep_pkg::CH_SEMI && m[5] && m[6]
                   && char_in == clep_pkg::CH_UPPER_H) begin
                  place_req = 1'b1;
                  place_col = clep_pkg::two_digits(e5, e6);
                  place_row = clep_pkg::two_digits(e2, e3);
               end
            end
         endcase

         esc_count_in = keep ? esc_count_ff + 3'd1 : POS_ESC;
      end else begin
         result.valid      = 1'b1;
         result.bus_byte   = char_in;
         result.reg_select = clep_pkg::RS_DATA;
      end

      if (place_req) begin
         if (place_row >= clep_pkg::CHAR_WIDTH'(lines)) begin
            row_clamped = clep_pkg::CHAR_WIDTH'(lines) - 8'd1;
         end else begin
            row_clamped = place_row;
         end
         current_row_in    = row_clamped[clep_pkg::ROW_WIDTH-1:0];
         result.valid      = 1'b1;
         result.bus_byte   = clep_pkg::CMD_SET_ADDR
                           | (place_col + clep_pkg::row_base(row_clamped[clep_pkg::ROW_WIDTH-1:0]));
         result.reg_select = clep_pkg::RS_COMMAND;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         esc_count_ff    <= POS_ESC;
         digit_mask_ff   <= '0;
         current_row_ff  <= '0;
         display_ctrl_ff <= clep_pkg::DISPLAY_CTRL_RESET;
      end else if (advance) begin
         esc_count_ff    <= esc_count_in;
         digit_mask_ff   <= digit_mask_in;
         current_row_ff  <= current_row_in;
         display_ctrl_ff <= display_ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         esc_chars_ff <= esc_chars_in;
      end
   end

endmodule

`default_nettype wire
